### sv/bbc_pkg.sv
// Package with the shared types, codes and character decoders of the bracket balance checker.
`timescale 1ns / 1ps

package bbc_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

  typedef logic [1:0] kind_t;
  typedef logic [1:0] status_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam kind_t KIND_ROUND = 2'd0;
  localparam kind_t KIND_SQUARE = 2'd1;
  localparam kind_t KIND_CURLY = 2'd2;
  localparam kind_t KIND_NONE = 2'd3;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_CLOSER = 2'd1;
  localparam status_t ST_UNCLOSED = 2'd2;
  localparam status_t ST_OVERFLOW = 2'd3;

  localparam logic [7:0] CH_ROUND_OPEN = 8'h28;
  localparam logic [7:0] CH_ROUND_CLOSE = 8'h29;
  localparam logic [7:0] CH_SQUARE_OPEN = 8'h5B;
  localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;
  localparam logic [7:0] CH_CURLY_OPEN = 8'h7B;
  localparam logic [7:0] CH_CURLY_CLOSE = 8'h7D;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

  function automatic kind_t opener_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_ROUND_OPEN: k = KIND_ROUND;
      CH_SQUARE_OPEN: k = KIND_SQUARE;
      CH_CURLY_OPEN: k = KIND_CURLY;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic kind_t closer_kind(input logic [7:0] c);
    kind_t k;
    case (c)
      CH_ROUND_CLOSE: k = KIND_ROUND;
      CH_SQUARE_CLOSE: k = KIND_SQUARE;
      CH_CURLY_CLOSE: k = KIND_CURLY;
      default: k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

### sv/bbc_if.sv
// Handshake interfaces for the character requests and the verdict requests.
`timescale 1ns / 1ps

interface bbc_text_if;
  logic valid;
  logic ready;
  logic [7:0] symbol;
  logic end_marker;

  modport source (output valid, output symbol, output end_marker, input ready);
  modport sink (input valid, input symbol, input end_marker, output ready);
endinterface

interface bbc_result_if;
  logic valid;
  logic ready;
  logic balanced;
  logic [1:0] status;

  modport source (output valid, output balanced, output status, input ready);
  modport sink (input valid, input balanced, input status, output ready);
endinterface

### sv/bbc_cell.sv
// One stack cell: holds a bracket kind and shifts it toward or away from the top.
`timescale 1ns / 1ps

module bbc_cell (
  input  logic           clk,
  input  bbc_pkg::shift_t ctl,
  input  bbc_pkg::kind_t  above,
  input  bbc_pkg::kind_t  below,
  output bbc_pkg::kind_t  kind
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      kind <= above;
    end else if (ctl.pop) begin
      kind <= below;
    end
  end

endmodule

### sv/bracket_balance_checker.sv
// Top level of the bracket balance checker: decoder, stack count, cell chain and verdict register.
`timescale 1ns / 1ps

// The checker takes one character request per clock cycle and gives one verdict request per
// end marker, in the cycle after the end marker is taken. The bracket stack is a chain of
// STACK_DEPTH cells whose top is the first cell; a push or a pop moves every entry by one cell in
// the same cycle, so no character holds up the next. Input is stalled only while a verdict waits
// in the output register and the result side is not ready. The first fault latches a status,
// and characters after it are ignored until the end marker, which also clears the stack.

module bracket_balance_checker (
  input  logic                clk,
  input  logic                rst,
  bbc_text_if.sink            text,
  bbc_result_if.source        result
);

  bbc_pkg::count_t count;
  bbc_pkg::status_t fail;
  bbc_pkg::kind_t kinds [bbc_pkg::STACK_DEPTH];
  bbc_pkg::kind_t open_kind;
  bbc_pkg::kind_t close_kind;
  bbc_pkg::shift_t ctl;
  bbc_pkg::status_t verdict;
  logic accept;
  logic step;
  logic full;
  logic empty;

  assign text.ready = !result.valid || result.ready;
  assign accept = text.valid && text.ready;
  assign step = accept && !text.end_marker && (fail == bbc_pkg::ST_OK);
  assign open_kind = bbc_pkg::opener_kind(text.symbol);
  assign close_kind = bbc_pkg::closer_kind(text.symbol);
  assign full = (count == bbc_pkg::COUNT_W'(bbc_pkg::STACK_DEPTH));
  assign empty = (count == '0);

  always_comb begin
    ctl.push = step && (open_kind != bbc_pkg::KIND_NONE) && !full;
    ctl.pop = step && (open_kind == bbc_pkg::KIND_NONE) &&
              (close_kind != bbc_pkg::KIND_NONE) && !empty && (kinds[0] == close_kind);
  end

  always_comb begin
    if (fail != bbc_pkg::ST_OK) begin
      verdict = fail;
    end else if (!empty) begin
      verdict = bbc_pkg::ST_UNCLOSED;
    end else begin
      verdict = bbc_pkg::ST_OK;
    end
  end

  for (genvar i = 0; i < bbc_pkg::STACK_DEPTH; i++) begin : g_cell
    bbc_pkg::kind_t above;
    bbc_pkg::kind_t below;
    if (i == 0) begin : g_top
      assign above = open_kind;
    end else begin : g_mid
      assign above = kinds[i-1];
    end
    if (i == bbc_pkg::STACK_DEPTH - 1) begin : g_bottom
      assign below = bbc_pkg::KIND_ROUND;
    end else begin : g_inner
      assign below = kinds[i+1];
    end
    bbc_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above),
      .below (below),
      .kind  (kinds[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      fail <= bbc_pkg::ST_OK;
    end else if (accept && text.end_marker) begin
      count <= '0;
      fail <= bbc_pkg::ST_OK;
    end else if (step) begin
      if (open_kind != bbc_pkg::KIND_NONE) begin
        if (full) begin
          fail <= bbc_pkg::ST_OVERFLOW;
        end else begin
          count <= count + bbc_pkg::COUNT_W'(1);
        end
      end else if (close_kind != bbc_pkg::KIND_NONE) begin
        if (ctl.pop) begin
          count <= count - bbc_pkg::COUNT_W'(1);
        end else begin
          fail <= bbc_pkg::ST_CLOSER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept && text.end_marker) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && text.end_marker) begin
      result.status <= verdict;
      result.balanced <= (verdict == bbc_pkg::ST_OK);
    end
  end

endmodule
